// ----- sv/utp_pkg.sv -----
// Package for the UUID text parser: item types, decode struct and status codes.
// No dependencies; every other file of the block imports it.
package utp_pkg;

   localparam int unsigned TEXT_LEN   = 36;
   localparam int unsigned BYTE_COUNT = 16;
   localparam int unsigned POS_SAT    = TEXT_LEN + 1;

   localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_LO_A   = 8'h61;
   localparam logic [7:0] CHAR_LO_F   = 8'h66;
   localparam logic [7:0] CHAR_UP_A   = 8'h41;
   localparam logic [7:0] CHAR_UP_F   = 8'h46;
   localparam logic [3:0] LETTER_BIAS = 4'd9;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_LENGTH   = 3'd1;
   localparam logic [2:0] ST_OVERFLOW = 3'd2;
   localparam logic [2:0] ST_SPLIT    = 3'd3;
   localparam logic [2:0] ST_BADHEX   = 3'd4;
   localparam logic [2:0] ST_SHORT    = 3'd5;

   typedef struct packed {
      logic [7:0] character;
      logic       final_char;
   } req_type;

   typedef struct packed {
      logic [63:0] uuid_upper;
      logic [63:0] uuid_lower;
      logic [2:0]  status;
   } rsp_type;

   typedef struct packed {
      logic       is_hyphen;
      logic       is_hex;
      logic [3:0] nibble;
   } decode_type;

endpackage

// ----- sv/uuid_text_parser.sv -----
// Top level of the UUID text parser: input register, parse logic, result register.
// Depends on utp_pkg and utp_assemble.
//
// The block takes one text character per item and may accept a new item every
// cycle. A character is registered on acceptance and processed from that
// register; on the character marked final, the 128-bit value and its status
// are loaded into the result register once no earlier result is still waiting
// to be taken. Hyphens are skipped, other characters pair into bytes as hex
// digits of either case, and on any error both value halves are zero. The input
// side stalls only when a final character waits for the result register while
// an earlier result has not yet been taken.
module uuid_text_parser
   import utp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_item_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_item_ff;
   rsp_type result;
   logic    s1_fire;
   logic    emit;

   utp_assemble u_assemble (
      .clock     (clock),
      .reset     (reset),
      .step      (s1_fire),
      .char_item (s1_item_ff),
      .result    (result)
   );

   always_comb begin
      s1_fire   = s1_valid_ff &&
                  (!s1_item_ff.final_char || !rsp_valid_ff || rsp_ready);
      emit      = s1_fire && s1_item_ff.final_char;
      req_ready = !s1_valid_ff || s1_fire;

      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_item_ff <= req_item;
      end
      if (emit) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ----- sv/utp_decode.sv -----
// Character classifier: hyphen detect, hex digit detect and nibble value.
// Depends on utp_pkg.
module utp_decode
   import utp_pkg::*;
(
   input  logic [7:0] character,
   output decode_type decode
);

   logic is_digit;
   logic is_letter;

   always_comb begin
      is_digit  = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
      is_letter = ((character >= CHAR_LO_A) && (character <= CHAR_LO_F)) ||
                  ((character >= CHAR_UP_A) && (character <= CHAR_UP_F));
      decode.is_hyphen = (character == CHAR_HYPHEN);
      decode.is_hex    = is_digit || is_letter;
      // Letters a..f and A..F both have low nibble 1..6, so adding nine gives 10..15.
      if (is_digit) begin
         decode.nibble = character[3:0];
      end else if (is_letter) begin
         decode.nibble = character[3:0] + LETTER_BIAS;
      end else begin
         decode.nibble = 4'd0;
      end
   end

endmodule

// ----- sv/utp_assemble.sv -----
// Parse state, byte assembly and status ranking for one character per step.
// Depends on utp_pkg and utp_decode.
module utp_assemble
   import utp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type char_item,
   output rsp_type result
);

   decode_type   dec;
   logic [5:0]   pos_ff,   pos_in;
   logic [4:0]   bp_ff,    bp_in;
   logic         open_ff,  open_in;
   logic [3:0]   nib_ff,   nib_in;
   logic         bad_ff,   bad_in;
   logic [2:0]   err_ff,   err_in;
   logic [127:0] value_ff, value_in;
   logic [2:0]   err_code;
   logic [2:0]   status;

   utp_decode u_decode (
      .character (char_item.character),
      .decode    (dec)
   );

   always_comb begin
      pos_in   = (pos_ff < 6'(POS_SAT)) ? pos_ff + 6'd1 : pos_ff;
      bp_in    = bp_ff;
      open_in  = open_ff;
      nib_in   = nib_ff;
      bad_in   = bad_ff;
      value_in = value_ff;
      err_code = ST_OK;

      if (!open_ff) begin
         if (!dec.is_hyphen) begin
            if (bp_ff[4]) begin
               err_code = ST_OVERFLOW;
            end else begin
               nib_in  = dec.nibble;
               bad_in  = !dec.is_hex;
               open_in = 1'b1;
            end
         end
      end else begin
         open_in = 1'b0;
         if (dec.is_hyphen) begin
            err_code = ST_SPLIT;
         end else if (bad_ff || !dec.is_hex) begin
            err_code = ST_BADHEX;
         end else if (!bp_ff[4]) begin
            // Byte 0 lands in the top byte of the 128-bit value.
            value_in[{~bp_ff[3:0], 3'b000} +: 8] = {nib_ff, dec.nibble};
            bp_in = bp_ff + 5'd1;
         end
      end

      err_in = (err_ff == ST_OK) ? err_code : err_ff;

      if (pos_in != 6'(TEXT_LEN)) begin
         status = ST_LENGTH;
      end else if (err_in != ST_OK) begin
         status = err_in;
      end else if (open_in) begin
         status = ST_SPLIT;
      end else if (bp_in != 5'(BYTE_COUNT)) begin
         status = ST_SHORT;
      end else begin
         status = ST_OK;
      end

      result.status     = status;
      result.uuid_upper = (status == ST_OK) ? value_in[127:64] : 64'd0;
      result.uuid_lower = (status == ST_OK) ? value_in[63:0]   : 64'd0;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && char_item.final_char)) begin
         pos_ff  <= 6'd0;
         bp_ff   <= 5'd0;
         open_ff <= 1'b0;
         nib_ff  <= 4'd0;
         bad_ff  <= 1'b0;
         err_ff  <= ST_OK;
      end else if (step) begin
         pos_ff  <= pos_in;
         bp_ff   <= bp_in;
         open_ff <= open_in;
         nib_ff  <= nib_in;
         bad_ff  <= bad_in;
         err_ff  <= err_in;
      end
   end

   // Every byte is rewritten before a good status can be reported, so the
   // value register needs no clearing between strings.
   always_ff @(posedge clock) begin
      if (step) begin
         value_ff <= value_in;
      end
   end

endmodule
